@@ src/wpd_pkg.sv @@
// Shared widths, register indexes, reset values and the result type of the peak decimator.
package wpd_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 8;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PEAK_W      = 16;
  localparam int unsigned CHANNEL_W   = 3;
  localparam int unsigned BIN_W       = 16;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned OUT_DEPTH   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_BIN = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = CFG_INDEX_W'(1);

  localparam logic [BIN_W-1:0]   SAMPLES_PER_BIN_RST = BIN_W'(256);
  localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST   = COUNT_W'(1);

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [PEAK_W-1:0]    peak;
    logic                 last_of_bin;
  } peak_item_t;

endpackage

@@ src/wpd_in_if.sv @@
// Sample stream channel: valid/ready with one interleaved sample per transaction.
interface wpd_in_if import wpd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       start_req;

  modport source (output valid, sample, start_req, input ready);
  modport sink   (input valid, sample, start_req, output ready);
endinterface

@@ src/wpd_out_if.sv @@
// Peak result channel: valid/ready with one channel peak per transaction.
interface wpd_out_if import wpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel;
  logic [PEAK_W-1:0]    peak;
  logic                 last_of_bin;

  modport source (output valid, channel, peak, last_of_bin, input ready);
  modport sink   (input valid, channel, peak, last_of_bin, output ready);
endinterface

@@ src/wpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wpd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/wpd_fifo.sv @@
// Small result queue that parts the peak readout from the output handshake.
module wpd_fifo import wpd_pkg::*; #(
  parameter int unsigned DEPTH = OUT_DEPTH,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned LW   = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  peak_item_t      push_data,
  output logic [LW-1:0]   level,
  wpd_out_if.source       out
);

  peak_item_t      entries [DEPTH];
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr;
  logic            pop;

  assign pop = out.valid && out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      level <= level + LW'(push) - LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign out.valid       = (level != '0);
  assign out.channel     = entries[rd_ptr].channel;
  assign out.peak        = entries[rd_ptr].peak;
  assign out.last_of_bin = entries[rd_ptr].last_of_bin;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level != LW'(DEPTH)))
    else $error("result queue overflow");

endmodule

@@ src/waveform_peak_decimator_unit.sv @@
// Top level of the peak-envelope decimator: config registers, two peak banks and readout.
//
// Takes one interleaved sample per clock and keeps each channel's running peak |sample| in one
// of two RAM banks (one read-modify-write per sample, with forwarding between back-to-back
// samples of the same channel). When a bin closes the banks swap: the new bin accumulates in
// the other bank while the closed bank is read out one channel per cycle while there is room
// into a 4-entry result queue; a bin's first peak goes through the readout register and the
// queue to the result port. The input stalls only when a sample that may close a bin
// arrives while the previous bin is still being read out, which happens only when the output
// side is held off; otherwise the sustained rate is one sample per clock for any channel count
// and bin length. Clearing of peaks is done by per-entry valid bits, so there is no clear sweep.
module waveform_peak_decimator_unit import wpd_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  wpd_in_if.sink                 stream,
  wpd_out_if.source              result
);

  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NW = ($clog2(MAX_CHANNELS + 1) > COUNT_W) ?
                               $clog2(MAX_CHANNELS + 1) : COUNT_W;
  localparam int unsigned LW = $clog2(OUT_DEPTH + 1);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_CHANNELS);

  // configuration
  logic [BIN_W-1:0]   samples_per_bin;
  logic [COUNT_W-1:0] channel_count;

  // bin position
  logic [CW-1:0]              channel_position;
  logic [BIN_W-1:0]           frame_position;
  logic                       active_bank;
  logic [1:0][MAX_CHANNELS-1:0] entry_valid;

  // decode
  logic               accept;
  logic [NW-1:0]      count_ext;
  logic [NW-1:0]      nch;
  logic [BIN_W-1:0]   spb;
  logic [CW-1:0]      cp;
  logic [BIN_W-1:0]   fp;
  logic               frame_close;
  logic               bin_close;
  logic               close_state;
  logic               close_fresh;
  logic               might_close;
  logic [SAMPLE_W-1:0] raw;
  logic [PEAK_W-1:0]  mag;

  // update stage
  logic               s1_v;
  logic               s1_bank;
  logic [CW-1:0]      s1_addr;
  logic [PEAK_W-1:0]  s1_mag;
  logic               s1_start;
  logic [PEAK_W-1:0]  old_peak;
  logic [PEAK_W-1:0]  new_peak;
  logic               w_en_q;
  logic               w_bank_q;
  logic [CW-1:0]      w_addr_q;
  logic [PEAK_W-1:0]  w_data_q;

  // readout
  logic               drain_busy;
  logic               drain_bank;
  logic [CW-1:0]      drain_idx;
  logic [CW-1:0]      drain_end;
  logic               drain_issue;
  logic               drain_last_issue;
  logic               drain_hit;
  logic               dq_v;
  logic               dq_bank;
  logic               dq_hit;
  logic [PEAK_W-1:0]  dq_hit_data;
  logic               dq_valid;
  logic [CW-1:0]      dq_chan;
  logic               dq_last;
  logic [LW-1:0]      fifo_level;
  peak_item_t         push_data;

  logic [CW-1:0]      ram_raddr [2];
  logic [PEAK_W-1:0]  ram_rdata [2];

  assign accept    = stream.valid && stream.ready;
  assign count_ext = NW'(channel_count);
  assign nch       = (count_ext == '0) ? NW'(1) : ((count_ext > MAX_N) ? MAX_N : count_ext);
  assign spb       = (samples_per_bin == '0) ? BIN_W'(1) : samples_per_bin;

  assign cp = stream.start_req ? '0 : channel_position;
  assign fp = stream.start_req ? '0 : frame_position;

  assign frame_close = (NW'(cp) + NW'(1)) >= nch;
  assign bin_close   = frame_close && (({1'b0, fp} + (BIN_W + 1)'(1)) >= {1'b0, spb});

  assign close_state = ((NW'(channel_position) + NW'(1)) >= nch) &&
                       (({1'b0, frame_position} + (BIN_W + 1)'(1)) >= {1'b0, spb});
  assign close_fresh = (nch == NW'(1)) && (spb == BIN_W'(1));
  assign might_close = close_state || close_fresh;

  assign raw = stream.sample;
  assign mag = raw[SAMPLE_W-1] ? PEAK_W'(~raw + SAMPLE_W'(1)) : PEAK_W'(raw);

  assign drain_issue      = drain_busy && ((fifo_level + LW'(dq_v)) < LW'(OUT_DEPTH));
  assign drain_last_issue = drain_issue && (drain_idx == drain_end);

  assign stream.ready = !(drain_busy && !drain_last_issue && might_close);

  // peak banks
  for (genvar b = 0; b < 2; b++) begin : g_bank
    assign ram_raddr[b] = (drain_busy && (drain_bank == 1'(b))) ? drain_idx : cp;

    wpd_ram #(
      .WIDTH (PEAK_W),
      .DEPTH (MAX_CHANNELS)
    ) u_bank (
      .clk   (clk),
      .we    (s1_v && (s1_bank == 1'(b))),
      .waddr (s1_addr),
      .wdata (new_peak),
      .raddr (ram_raddr[b]),
      .rdata (ram_rdata[b])
    );
  end

  always_comb begin
    if (s1_start) begin
      old_peak = '0;
    end else if (w_en_q && (w_bank_q == s1_bank) && (w_addr_q == s1_addr)) begin
      old_peak = w_data_q;
    end else if (entry_valid[s1_bank][s1_addr]) begin
      old_peak = ram_rdata[s1_bank];
    end else begin
      old_peak = '0;
    end
  end

  assign new_peak = (s1_mag > old_peak) ? s1_mag : old_peak;

  assign drain_hit = s1_v && (s1_bank == drain_bank) && (s1_addr == drain_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_bin  <= SAMPLES_PER_BIN_RST;
      channel_count    <= CHANNEL_COUNT_RST;
      channel_position <= '0;
      frame_position   <= '0;
      active_bank      <= 1'b0;
      entry_valid      <= '0;
      s1_v             <= 1'b0;
      w_en_q           <= 1'b0;
      drain_busy       <= 1'b0;
      drain_bank       <= 1'b0;
      drain_idx        <= '0;
      drain_end        <= '0;
      dq_v             <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_SAMPLES_PER_BIN: samples_per_bin <= cfg_data[BIN_W-1:0];
          REG_CHANNEL_COUNT:   channel_count   <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      s1_v   <= accept;
      w_en_q <= s1_v;
      dq_v   <= drain_issue;

      if (s1_v) begin
        entry_valid[s1_bank][s1_addr] <= 1'b1;
      end

      // clears from the newer transaction win over the older write
      if (accept) begin
        if (stream.start_req) begin
          entry_valid[active_bank] <= '0;
        end
        if (frame_close) begin
          channel_position <= '0;
          frame_position   <= bin_close ? '0 : fp + BIN_W'(1);
        end else begin
          channel_position <= cp + CW'(1);
          frame_position   <= fp;
        end
        if (bin_close) begin
          entry_valid[~active_bank] <= '0;
          active_bank <= ~active_bank;
        end
      end

      if (accept && bin_close) begin
        drain_busy <= 1'b1;
        drain_bank <= active_bank;
        drain_idx  <= '0;
        drain_end  <= CW'(nch - NW'(1));
      end else if (drain_last_issue) begin
        drain_busy <= 1'b0;
      end else if (drain_issue) begin
        drain_idx <= drain_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_bank     <= active_bank;
    s1_addr     <= cp;
    s1_mag      <= mag;
    s1_start    <= stream.start_req;
    w_bank_q    <= s1_bank;
    w_addr_q    <= s1_addr;
    w_data_q    <= new_peak;
    dq_bank     <= drain_bank;
    dq_hit      <= drain_hit;
    dq_hit_data <= new_peak;
    dq_valid    <= entry_valid[drain_bank][drain_idx] || drain_hit;
    dq_chan     <= drain_idx;
    dq_last     <= (drain_idx == drain_end);
  end

  always_comb begin
    push_data.channel     = CHANNEL_W'(dq_chan);
    push_data.last_of_bin = dq_last;
    if (dq_hit) begin
      push_data.peak = dq_hit_data;
    end else if (dq_valid) begin
      push_data.peak = ram_rdata[dq_bank];
    end else begin
      push_data.peak = '0;
    end
  end

  wpd_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (dq_v),
    .push_data (push_data),
    .level     (fifo_level),
    .out       (result)
  );

  a_close_needs_drain_slot: assert property (@(posedge clk) disable iff (rst)
    (accept && bin_close) |-> (!drain_busy || drain_last_issue))
    else $error("bin closed while previous readout still pending");

  a_banks_apart: assert property (@(posedge clk) disable iff (rst)
    drain_busy |-> (drain_bank != active_bank))
    else $error("readout bank is the accumulating bank");

  a_drain_in_range: assert property (@(posedge clk) disable iff (rst)
    drain_issue |-> (drain_idx <= drain_end))
    else $error("readout index past last channel");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the peak-envelope decimator: directed rows, then random sample bursts.
module testbench import wpd_pkg::*; ();

  localparam int unsigned TOTAL_SAMPLES = 460;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef enum logic [0:0] {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
    logic                   start;
    logic                   typed;
    peak_item_t             result;
  } stim_row_t;

  localparam peak_item_t NO_PEAK = '{3'd0, 16'h0000, 1'b0};
  localparam int unsigned N_ROWS = 32;

  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{ROW_SAMPLE, '0, 16'h1234, 1'b1, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'hFFFB, 1'b0, 1'b0, NO_PEAK},
    '{ROW_WRITE, REG_SAMPLES_PER_BIN, 16'd1, 1'b0, 1'b0, NO_PEAK},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 16'd1, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0001, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b0, 1'b1, '{3'd0, 16'h8000, 1'b1}},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, 1'b1, '{3'd0, 16'h7FFF, 1'b1}},
    '{ROW_SAMPLE, '0, 16'h0000, 1'b0, 1'b1, '{3'd0, 16'h0000, 1'b1}},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, 1'b1, '{3'd0, 16'h0001, 1'b1}},
    '{ROW_WRITE, REG_SAMPLES_PER_BIN, 16'd0, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h5555, 1'b0, 1'b1, '{3'd0, 16'h5555, 1'b1}},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 16'd0, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'hAAAA, 1'b0, 1'b1, '{3'd0, 16'h5556, 1'b1}},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 16'd15, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b1, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0000, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0001, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h4000, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'hC000, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h2AAA, 1'b0, 1'b0, NO_PEAK},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 16'd3, 1'b0, 1'b0, NO_PEAK},
    '{ROW_WRITE, REG_SAMPLES_PER_BIN, 16'd2, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0100, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'hF000, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0010, 1'b1, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0020, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0030, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'hFFF0, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0001, 1'b0, 1'b0, NO_PEAK},
    '{ROW_SAMPLE, '0, 16'h0002, 1'b0, 1'b0, NO_PEAK}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  wpd_in_if  stream_if ();
  wpd_out_if result_if ();

  waveform_peak_decimator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stream       (stream_if),
    .result       (result_if)
  );

  // predictor state
  logic [BIN_W-1:0]   bin_frames;
  logic [COUNT_W-1:0] lane_count;
  int unsigned        lane_pos;
  int unsigned        frame_pos;
  logic [16:0]        lane_peak [MAX_CHANNELS_DEF];
  peak_item_t         peak_queue [$];

  int unsigned mismatches;
  int unsigned peaks_checked;
  int unsigned samples_sent;
  int unsigned setups;
  int unsigned cycles;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d peaks outstanding", cycles, peak_queue.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) result_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0h expected %0h (peak %0d)", what, got, want, peaks_checked);
    mismatches++;
  endtask

  function automatic void queue_peak(input peak_item_t item);
    peak_queue.insert(peak_queue.size(), item);
  endfunction

  always @(posedge clk) begin
    peak_item_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (peak_queue.size() == 0) begin
        report_mismatch("unexpected peak", result_if.peak, 0);
      end else begin
        want = peak_queue.pop_front();
        if (result_if.channel !== want.channel)
          report_mismatch("channel", result_if.channel, want.channel);
        if (result_if.peak !== want.peak)
          report_mismatch("peak", result_if.peak, want.peak);
        if (result_if.last_of_bin !== want.last_of_bin)
          report_mismatch("last_of_bin", result_if.last_of_bin, want.last_of_bin);
      end
      peaks_checked++;
    end
  end

  task automatic predict_peaks(input logic [15:0] s, input logic st, input bit record);
    int unsigned lanes;
    int unsigned frames;
    int unsigned ch;
    int unsigned k;
    logic [16:0] mag;
    peak_item_t  item;
    lanes  = (lane_count == 0) ? 1 : ((lane_count > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF
                                                                     : lane_count);
    frames = (bin_frames == 0) ? 1 : bin_frames;
    mag    = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    if (st) begin
      lane_pos  = 0;
      frame_pos = 0;
      for (k = 0; k < MAX_CHANNELS_DEF; k++) lane_peak[k] = '0;
    end
    ch = (lane_pos >= MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF - 1 : lane_pos;
    if (mag > lane_peak[ch]) lane_peak[ch] = mag;
    if (lane_pos + 1 >= lanes) begin
      lane_pos = 0;
      if (frame_pos + 1 >= frames) begin
        for (k = 0; k < lanes; k++) begin
          item.channel     = k[CHANNEL_W-1:0];
          item.peak        = lane_peak[k][PEAK_W-1:0];
          item.last_of_bin = (k + 1 == lanes);
          if (record) queue_peak(item);
        end
        for (k = 0; k < MAX_CHANNELS_DEF; k++) lane_peak[k] = '0;
        frame_pos = 0;
      end else begin
        frame_pos = (frame_pos + 1) & 32'hFFFF;
      end
    end else begin
      lane_pos++;
    end
  endtask

  task automatic send_sample(input logic [15:0] s, input logic st, input bit record);
    if (samples_sent < TOTAL_SAMPLES / 3) begin
      src_idle_pct = 16;
      snk_idle_pct = 69;
    end else if (samples_sent < 2 * TOTAL_SAMPLES / 3) begin
      src_idle_pct = 69;
      snk_idle_pct = 16;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < src_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid     <= 1'b1;
    stream_if.sample    <= s;
    stream_if.start_req <= st;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    samples_sent++;
    predict_peaks(s, st, record);
  endtask

  task automatic drain_peaks(input bit settle);
    stream_if.valid <= 1'b0;
    do @(posedge clk); while (peak_queue.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_SAMPLES_PER_BIN) bin_frames = value[BIN_W-1:0];
    else if (idx == REG_CHANNEL_COUNT) lane_count = value[COUNT_W-1:0];
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned frames;
    int unsigned lanes_raw;
    int unsigned lanes;
    int unsigned n_items;
    int unsigned k;
    bit          fresh;
    logic [15:0] s;
    logic        st;

    rst                 = 1'b1;
    cfg_write_en        = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    stream_if.valid     = 1'b0;
    stream_if.sample    = '0;
    stream_if.start_req = 1'b0;
    src_idle_pct        = 16;
    snk_idle_pct        = 69;
    bin_frames          = SAMPLES_PER_BIN_RST;
    lane_count          = CHANNEL_COUNT_RST;
    lane_pos            = 0;
    frame_pos           = 0;
    for (k = 0; k < MAX_CHANNELS_DEF; k++) lane_peak[k] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_ROWS; k++) begin
      if (DIRECTED[k].kind == ROW_WRITE) begin
        drain_peaks(1'b1);
        set_reg(DIRECTED[k].index, DIRECTED[k].value);
        setups++;
      end else begin
        send_sample(DIRECTED[k].value, DIRECTED[k].start, !DIRECTED[k].typed);
        if (DIRECTED[k].typed) queue_peak(DIRECTED[k].result);
      end
    end

    phase = 0;
    while (samples_sent < TOTAL_SAMPLES) begin
      case (phase)
        0: begin
          frames = 65535; lanes_raw = 8; n_items = 30; fresh = 1'b1;
        end
        1: begin
          frames = 1; lanes_raw = 8; n_items = 40; fresh = 1'b0;
        end
        2: begin
          frames = 0; lanes_raw = 9; n_items = 27; fresh = 1'b1;
        end
        default: begin
          frames    = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
          lanes_raw = ($urandom_range(0, 5) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 15);
          lanes     = (lanes_raw == 0) ? 1 : ((lanes_raw > 8) ? 8 : lanes_raw);
          n_items   = $urandom_range(1, 3) * frames * lanes;
          if (n_items > 96) n_items = 96;
          if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, lanes);
          fresh     = ($urandom_range(0, 2) != 0);
        end
      endcase
      drain_peaks(1'b1);
      set_reg(REG_SAMPLES_PER_BIN, frames[CFG_DATA_W-1:0]);
      set_reg(REG_CHANNEL_COUNT, lanes_raw[CFG_DATA_W-1:0]);
      setups++;
      for (k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 15))
          0:       s = 16'h8000;
          1:       s = 16'h7FFF;
          2:       s = 16'h0000;
          3:       s = 16'hFFFF;
          default: s = 16'($urandom);
        endcase
        st = (k == 0 && fresh) || ($urandom_range(0, 39) == 0);
        send_sample(s, st, 1'b1);
        if ($urandom_range(0, 79) == 0) drain_peaks(1'b0);
      end
      phase++;
    end

    drain_peaks(1'b1);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (peak_queue.size() != 0) report_mismatch("peaks never seen", 0, peak_queue.size());
    $display("run covered %0d samples over %0d register setups, %0d peaks checked",
             samples_sent, setups, peaks_checked);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
